// File: hw/rtl/sgi_pkg.sv
// shared widths, register indexes and corner codes for the serpentine grid index block
package sgi_pkg;

   localparam int STEP_W     = 21;
   localparam int DIM_W      = 11;
   localparam int QUOT_W     = DIM_W;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam int LIM_W      = 17;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_COLUMNWISE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CORNER    = 2'd3;

   localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
   localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd1;
   localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd2;
   localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd3;

   typedef struct packed {
      logic right_start;
      logic bottom_start;
   } corner_type;

endpackage

// File: hw/rtl/serpentine_grid_index_top.sv
// serpentine grid index: step number on a snake walk to row-major cell number
//
// Usage: grid size, scan direction and start corner are written on the csr_
// channel (always ready) while no word is in flight. Each word taken on the
// req_ channel carries a 1-based step; one word leaves on the rsp_ channel
// with the 1-based row-major cell and an out-of-range flag (step 0 or past
// rows*cols gives cell 0 with the flag set).
// Pipeline: a word accepted on req_ passes the entry stage, one
// restoring-division stage per quotient bit (11 bits) and the map and
// multiply stages before it appears on rsp_.
// Throughput: one word per clock; a new word is taken every cycle unless rsp_ stalls.
// Stalls: when rsp_ready is low the last stage holds its word, and each
// stage upstream keeps moving as long as the stage after it is empty or
// moving, so bubbles are squeezed out and nothing is lost or repeated.
// req_ready drops only when every stage holds a word.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// grid to 1 by 1, row-wise, starting top-left.
module serpentine_grid_index_top
   import sgi_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [STEP_W-1:0]     req_step,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STEP_W-1:0]     rsp_cell_res,
   output logic                  rsp_out_of_range
);

   localparam int NS = QUOT_W + 2;
   localparam int MAP_S = QUOT_W + 1;
   localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);
   localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);

   // configuration registers
   logic [DIM_W-1:0] grid_rows_ff, grid_cols_ff;
   logic             scan_columnwise_ff;
   logic [1:0]       start_corner_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff       <= DIM_W'(1);
         grid_cols_ff       <= DIM_W'(1);
         scan_columnwise_ff <= 1'b0;
         start_corner_ff    <= CORNER_TOP_LEFT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_ROWS:       grid_rows_ff       <= csr_data;
            CSR_GRID_COLS:       grid_cols_ff       <= csr_data;
            CSR_SCAN_COLUMNWISE: scan_columnwise_ff <= csr_data[0];
            CSR_START_CORNER:    start_corner_ff    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // effective grid, clamped to the build limits
   logic [DIM_W-1:0]  rows_eff, cols_eff, divisor;
   logic [PROD_W-1:0] total;
   corner_type        corner;

   always_comb begin
      rows_eff = ({(LIM_W-DIM_W)'(0), grid_rows_ff} > ROW_LIM) ? ROW_LIM[DIM_W-1:0]
                                                                 : grid_rows_ff;
      cols_eff = ({(LIM_W-DIM_W)'(0), grid_cols_ff} > COL_LIM) ? COL_LIM[DIM_W-1:0]
                                                                 : grid_cols_ff;
      divisor  = scan_columnwise_ff ? rows_eff : cols_eff;
      total    = rows_eff * cols_eff;
      corner.right_start  = (start_corner_ff == CORNER_TOP_RIGHT) ||
                            (start_corner_ff == CORNER_BOTTOM_RIGHT);
      corner.bottom_start = (start_corner_ff == CORNER_BOTTOM_RIGHT) ||
                            (start_corner_ff == CORNER_BOTTOM_LEFT);
   end

   // stage registers: 0 entry, 1..QUOT_W divider, MAP_S map, NS output
   logic [NS:0]       valid_ff;
   logic [NS:0]       oor_ff;
   logic [NS:0]       adv;
   logic [STEP_W-1:0] rem_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] quot_ff [0:QUOT_W];

   always_comb begin
      adv[NS] = !valid_ff[NS] || rsp_ready;
      for (int s = NS - 1; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign req_ready = adv[0];

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         oor_ff[0]  <= (req_step == '0) || ({1'b0, req_step} > total);
         rem_ff[0]  <= req_step - STEP_W'(1);
         quot_ff[0] <= '0;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar s = 1; s <= QUOT_W; s++) begin : g_div
      localparam int B = QUOT_W - s;
      logic [STEP_W:0] shifted;
      logic            fits;

      assign shifted = (STEP_W+1)'(divisor) << B;
      assign fits    = ({1'b0, rem_ff[s-1]} >= shifted);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            oor_ff[s]  <= oor_ff[s-1];
            rem_ff[s]  <= fits ? rem_ff[s-1] - shifted[STEP_W-1:0] : rem_ff[s-1];
            quot_ff[s] <= quot_ff[s-1] | (fits ? (QUOT_W'(1) << B) : '0);
         end
      end
   end

   // map line and position to row and column
   logic [DIM_W-1:0] line, pos, row_in, col_in;
   logic [DIM_W-1:0] row_ff, col_ff;
   logic             odd;

   always_comb begin
      line = quot_ff[QUOT_W];
      pos  = rem_ff[QUOT_W][DIM_W-1:0];
      odd  = line[0];
      if (!scan_columnwise_ff) begin
         row_in = corner.bottom_start ? rows_eff - DIM_W'(1) - line : line;
         col_in = (corner.right_start != odd) ? cols_eff - DIM_W'(1) - pos : pos;
      end else begin
         col_in = corner.right_start ? cols_eff - DIM_W'(1) - line : line;
         row_in = (corner.bottom_start != odd) ? rows_eff - DIM_W'(1) - pos : pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[MAP_S] <= 1'b0;
      end else if (adv[MAP_S]) begin
         valid_ff[MAP_S] <= valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[MAP_S]) begin
         oor_ff[MAP_S] <= oor_ff[QUOT_W];
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

   // output stage: row * cols + col + 1
   logic [PROD_W-1:0] cell_in;
   logic [STEP_W-1:0] cell_ff;

   assign cell_in = row_ff * cols_eff + PROD_W'(col_ff) + PROD_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[NS] <= 1'b0;
      end else if (adv[NS]) begin
         valid_ff[NS] <= valid_ff[MAP_S];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NS]) begin
         oor_ff[NS] <= oor_ff[MAP_S];
         cell_ff    <= oor_ff[MAP_S] ? '0 : cell_in[STEP_W-1:0];
      end
   end

   assign rsp_valid        = valid_ff[NS];
   assign rsp_cell_res     = cell_ff;
   assign rsp_out_of_range = oor_ff[NS];

   // an in-range word leaves the divider with a remainder below the line length
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[QUOT_W] && !oor_ff[QUOT_W] |-> rem_ff[QUOT_W] < STEP_W'(divisor))
      else $error("division remainder not below line length");

   // step zero is flagged at entry
   a_zero_step_flagged: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_step == '0) |=> valid_ff[0] && oor_ff[0])
      else $error("step zero not flagged out of range");

   // a flagged result carries cell zero
   a_oor_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_cell_res == '0)
      else $error("out-of-range word with nonzero cell");

   // the last stage holds a word the receiver has not taken
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS] && !rsp_ready |=> valid_ff[NS] && $stable(cell_ff))
      else $error("output word lost during stall");

endmodule
